// ===== rtl/bbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrl_pkg
// types and constants shared by the bounding box region lookup unit
// ----------------------------------------------------------------------------
package bbrl_pkg;

  localparam int COORD_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int REGION_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_FIRST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GROW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_Z     = 1'd1;

  localparam logic signed [COORD_W-1:0] COORD_POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_NEG_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_GROW,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [REGION_W-1:0]        region;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/bbrl_in_if.sv =====
// ----------------------------------------------------------------------------
// bbrl_in_if
// input channel: vertex and query transactions
// ----------------------------------------------------------------------------
interface bbrl_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [bbrl_pkg::FUNC_W-1:0]              func;
  logic [bbrl_pkg::REGION_W-1:0]            region_index;
  logic signed [bbrl_pkg::COORD_W-1:0]      x_coord;
  logic signed [bbrl_pkg::COORD_W-1:0]      y_coord;
  logic signed [bbrl_pkg::COORD_W-1:0]      z_coord;

  modport source (output valid, func, region_index, x_coord, y_coord, z_coord,
                  input ready);
  modport sink (input valid, func, region_index, x_coord, y_coord, z_coord,
                output ready);
endinterface

// ===== rtl/bbrl_out_if.sv =====
// ----------------------------------------------------------------------------
// bbrl_out_if
// result channel: query lookup transactions
// ----------------------------------------------------------------------------
interface bbrl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [bbrl_pkg::REGION_W-1:0]   match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink (input valid, found, match_index, output ready);
endinterface

// ===== rtl/bounding_box_region_lookup_unit.sv =====
// a first vertex is written as the engine takes it from the queue; a further
// vertex is read, merged and written back in ST_GROW; a query scans in ST_SCAN
// unless region_count is 0, and its result waits in ST_DONE until the result
// channel is free. The engine takes a new item only when idle; the box store's one
// read port scans one region per cycle; a 2-entry queue keeps the input accepting
// reset: synchronous, active high; all boxes empty, region_count 0, ignore_z 1
// ----------------------------------------------------------------------------
// bounding_box_region_lookup_unit
// per-region axis aligned boxes in q16.16 with first-match point lookup
// ----------------------------------------------------------------------------
module bounding_box_region_lookup_unit #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bbrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbrl_pkg::CFG_DATA_W-1:0]      cfg_data,
  bbrl_in_if.sink                              item_in,
  bbrl_out_if.source                           result_out
);
  import bbrl_pkg::*;

  logic [COUNT_W-1:0]  region_count;
  logic                ignore_z;
  logic                push;
  item_t               push_item;
  logic                pop;
  item_t               head;
  q_status_t           q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      ignore_z     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_COUNT: region_count <= cfg_data[COUNT_W-1:0];
        REG_IGNORE_Z:     ignore_z     <= cfg_data[0];
        default:          ignore_z     <= ignore_z;
      endcase
    end
  end

  bbrl_front #(.MAX_REGIONS(MAX_REGIONS)) u_front (
    .item_in   (item_in),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  bbrl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  bbrl_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .region_count (region_count),
    .ignore_z     (ignore_z),
    .result_out   (result_out)
  );

  a_queue_status : assert property (@(posedge clk) disable iff (rst)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("engine took an item from an empty queue");

  a_miss_index : assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.found) |-> (result_out.match_index == '0))
    else $error("miss result carries a nonzero index");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    (q_stat.full && !pop) |=> !(push && $past(q_stat.full)) || pop)
    else $error("push into a full queue");

endmodule

// ===== rtl/bbrl_front.sv =====
// ----------------------------------------------------------------------------
// bbrl_front
// accepts input transactions, drops unused codes and out of range vertices
// ----------------------------------------------------------------------------
module bbrl_front #(
  parameter int MAX_REGIONS = 16
) (
  bbrl_in_if.sink               item_in,
  input  bbrl_pkg::q_status_t   q_stat,
  output logic                  push,
  output bbrl_pkg::item_t       push_item
);
  import bbrl_pkg::*;

  logic in_range;
  logic keep;

  assign item_in.ready = !q_stat.full;
  assign in_range      = 32'(item_in.region_index) < MAX_REGIONS;

  always_comb begin
    keep             = 1'b0;
    push_item.op     = OP_QUERY;
    push_item.region = item_in.region_index;
    push_item.x      = item_in.x_coord;
    push_item.y      = item_in.y_coord;
    push_item.z      = item_in.z_coord;
    unique case (item_in.func)
      FUNC_FIRST: begin
        keep         = in_range;
        push_item.op = OP_FIRST;
      end
      FUNC_GROW: begin
        keep         = in_range;
        push_item.op = OP_GROW;
      end
      FUNC_QUERY: begin
        keep         = 1'b1;
        push_item.op = OP_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = item_in.valid && item_in.ready && keep;

endmodule

// ===== rtl/bbrl_queue.sv =====
// ----------------------------------------------------------------------------
// bbrl_queue
// short fifo between the front classifier and the back engine
// ----------------------------------------------------------------------------
module bbrl_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bbrl_pkg::item_t      push_item,
  input  logic                 pop,
  output bbrl_pkg::item_t      head,
  output bbrl_pkg::q_status_t  q_stat
);
  import bbrl_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = count == '0;
  assign q_stat.full  = count == CW'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bbrl_back.sv =====
// ----------------------------------------------------------------------------
// bbrl_back
// box store and engine: writes vertices, scans boxes for queries
// ----------------------------------------------------------------------------
module bbrl_back #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bbrl_pkg::q_status_t                q_stat,
  input  bbrl_pkg::item_t                    head,
  output logic                               pop,
  input  logic [bbrl_pkg::COUNT_W-1:0]       region_count,
  input  logic                               ignore_z,
  bbrl_out_if.source                         result_out
);
  import bbrl_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int NW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROW,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                     state;
  box_t                       mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0]     valid_bits;
  box_t                       rd_box;
  logic                       rd_valid;
  logic [IW-1:0]              scan_idx;
  logic [IW-1:0]              last_idx;
  logic [IW-1:0]              addr;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  py;
  logic signed [COORD_W-1:0]  pz;
  logic                       res_found;
  logic [REGION_W-1:0]        res_index;

  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  box_t                       wr_box;
  logic [NW-1:0]              cnt_ext;
  logic [NW-1:0]              n_clamped;
  logic [IW-1:0]              head_addr;
  logic [IW-1:0]              scan_next;
  logic                       hit;
  logic                       out_free;

  assign cnt_ext   = NW'(region_count);
  assign n_clamped = (cnt_ext > NW'(MAX_REGIONS)) ? NW'(MAX_REGIONS) : cnt_ext;
  assign head_addr = IW'(head.region);
  assign scan_next = (scan_idx == IW'(MAX_REGIONS - 1)) ? '0 : scan_idx + 1'b1;
  assign pop       = (state == ST_IDLE) && !q_stat.empty;
  assign out_free  = !result_out.valid || result_out.ready;

  assign hit = rd_valid
            && (rd_box.min_x <= px) && (px <= rd_box.max_x)
            && (rd_box.min_y <= py) && (py <= rd_box.max_y)
            && (ignore_z || ((rd_box.min_z <= pz) && (pz <= rd_box.max_z)));

  // read and write port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_addr;
    wr_en   = 1'b0;
    wr_addr = head_addr;
    wr_box  = '{min_x: head.x, min_y: head.y, min_z: head.z,
                max_x: head.x, max_y: head.y, max_z: head.z};
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          unique case (head.op)
            OP_FIRST: wr_en = 1'b1;
            OP_GROW: rd_en = 1'b1;
            OP_QUERY: begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
            default: rd_en = 1'b0;
          endcase
        end
      end
      ST_GROW: begin
        wr_en   = 1'b1;
        wr_addr = addr;
        if (rd_valid) begin
          wr_box.min_x = (px < rd_box.min_x) ? px : rd_box.min_x;
          wr_box.min_y = (py < rd_box.min_y) ? py : rd_box.min_y;
          wr_box.min_z = (pz < rd_box.min_z) ? pz : rd_box.min_z;
          wr_box.max_x = (px > rd_box.max_x) ? px : rd_box.max_x;
          wr_box.max_y = (py > rd_box.max_y) ? py : rd_box.max_y;
          wr_box.max_z = (pz > rd_box.max_z) ? pz : rd_box.max_z;
        end else begin
          wr_box = '{min_x: px, min_y: py, min_z: pz,
                     max_x: px, max_y: py, max_z: pz};
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = scan_next;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_box;
    end
    if (rd_en) begin
      rd_box <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid_bits[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      result_out.valid  <= 1'b0;
      result_out.found  <= 1'b0;
      result_out.match_index <= '0;
      scan_idx          <= '0;
      last_idx          <= '0;
      addr              <= '0;
      px                <= '0;
      py                <= '0;
      pz                <= '0;
      res_found         <= 1'b0;
      res_index         <= '0;
    end else begin
      if (result_out.valid && result_out.ready && state != ST_DONE) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            px   <= head.x;
            py   <= head.y;
            pz   <= head.z;
            addr <= head_addr;
            unique case (head.op)
              OP_FIRST: state <= ST_IDLE;
              OP_GROW: state <= ST_GROW;
              OP_QUERY: begin
                scan_idx <= '0;
                last_idx <= IW'(n_clamped - 1'b1);
                if (n_clamped == '0) begin
                  res_found <= 1'b0;
                  res_index <= '0;
                  state     <= ST_DONE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_GROW: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (hit) begin
            res_found <= 1'b1;
            res_index <= REGION_W'(scan_idx);
            state     <= ST_DONE;
          end else if (scan_idx == last_idx) begin
            res_found <= 1'b0;
            res_index <= '0;
            state     <= ST_DONE;
          end else begin
            scan_idx <= scan_next;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result_out.valid       <= 1'b1;
            result_out.found       <= res_found;
            result_out.match_index <= res_index;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// bounding_box_region_lookup_unit: vertex and query transactions are driven
// with random gaps and receiver stalls; a predictor keeps its own box store
// and register copies and every lookup result is checked in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bbrl_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                found;
    logic [REGION_W-1:0] index;
  } lookup_t;

  localparam int                NUM_REGIONS   = 16;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
  localparam int                SETTLE_CYCLES = 32;
  localparam int                STALL_LIMIT   = 5000;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                RANDOM_PHASES = 12;
  localparam int                PHASE_ITEMS   = 115;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bbrl_in_if  item_bus ();
  bbrl_out_if result_bus ();

  bounding_box_region_lookup_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_bus),
    .result_out (result_bus)
  );

  // predictor state
  coord_t             lo_x [NUM_REGIONS];
  coord_t             lo_y [NUM_REGIONS];
  coord_t             lo_z [NUM_REGIONS];
  coord_t             hi_x [NUM_REGIONS];
  coord_t             hi_y [NUM_REGIONS];
  coord_t             hi_z [NUM_REGIONS];
  logic [COUNT_W-1:0] search_count;
  logic               skip_z;

  lookup_t pending_lookups [$];
  int      mismatch_count = 0;
  int      hold_request   = 0;
  bit      no_gaps        = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_t predict_lookup(coord_t x, coord_t y, coord_t z);
    lookup_t res;
    int      n;
    res = '0;
    n = (search_count > NUM_REGIONS) ? NUM_REGIONS : search_count;
    for (int r = n - 1; r >= 0; r--) begin
      if (lo_x[r] <= x && x <= hi_x[r] && lo_y[r] <= y && y <= hi_y[r] &&
          (skip_z || (lo_z[r] <= z && z <= hi_z[r]))) begin
        res.found = 1'b1;
        res.index = r[REGION_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = $urandom_range(1) ? COORD_POS_MAX : COORD_NEG_MIN;
      2: v = coord_t'($urandom_range(64)) - 32;
      default: v = (coord_t'($urandom_range(64)) - 32) <<< 12;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic apply_item(input logic [FUNC_W-1:0] func, input logic [REGION_W-1:0] region,
                            input coord_t x, input coord_t y, input coord_t z);
    case (func)
      FUNC_FIRST: begin
        lo_x[region] = x; hi_x[region] = x;
        lo_y[region] = y; hi_y[region] = y;
        lo_z[region] = z; hi_z[region] = z;
      end
      FUNC_GROW: begin
        if (x < lo_x[region]) lo_x[region] = x;
        if (y < lo_y[region]) lo_y[region] = y;
        if (z < lo_z[region]) lo_z[region] = z;
        if (x > hi_x[region]) hi_x[region] = x;
        if (y > hi_y[region]) hi_y[region] = y;
        if (z > hi_z[region]) hi_z[region] = z;
      end
      FUNC_QUERY: pending_lookups = {pending_lookups, predict_lookup(x, y, z)};
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [REGION_W-1:0] region,
                           input coord_t x, input coord_t y, input coord_t z);
    while (!no_gaps && $urandom_range(99) < 10) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.func         <= func;
    item_bus.region_index <= region;
    item_bus.x_coord      <= x;
    item_bus.y_coord      <= y;
    item_bus.z_coord      <= z;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    apply_item(func, region, x, y, z);
  endtask

  task automatic drain_results();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [COUNT_W-1:0] count, input logic iz);
    logic [CFG_DATA_W-1:0] iz_word;
    iz_word = {4'($urandom_range(15)), iz};
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    search_count = count;
    cfg_index <= REG_IGNORE_Z;
    cfg_data  <= iz_word;
    @(posedge clk);
    skip_z = iz_word[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_regions();
    send_item(FUNC_QUERY, 4'd0, 0, 0, 0);
    settle();
    configure(5'd16, 1'b1);
    send_item(FUNC_QUERY, 4'd0, COORD_POS_MAX, COORD_POS_MAX, COORD_POS_MAX);
    send_item(FUNC_QUERY, 4'd9, COORD_NEG_MIN, COORD_NEG_MIN, COORD_NEG_MIN);
    send_item(FUNC_QUERY, 4'd15, 0, 0, 0);
  endtask

  task automatic test_vertex_updates();
    send_item(FUNC_FIRST, 4'd0, COORD_NEG_MIN, COORD_NEG_MIN, COORD_NEG_MIN);
    send_item(FUNC_GROW, 4'd0, COORD_POS_MAX, COORD_POS_MAX, COORD_POS_MAX);
    send_item(FUNC_QUERY, 4'd0, 32'sh1234_5678, -32'sh0765_4321, 0);
    send_item(FUNC_GROW, 4'd5, 100, 200, 300);
    send_item(FUNC_FIRST, 4'd0, 1000, 1000, 1000);
    send_item(FUNC_QUERY, 4'd0, 100, 200, 999);
    send_item(FUNC_QUERY, 4'd0, 101, 200, 300);
    // unused function code leaves the boxes alone
    send_item(FUNC_UNUSED, 4'd5, 101, 200, 300);
    send_item(FUNC_QUERY, 4'd0, 101, 200, 300);
    send_item(FUNC_FIRST, 4'd15, COORD_POS_MAX, COORD_POS_MAX, COORD_POS_MAX);
    send_item(FUNC_QUERY, 4'd3, COORD_POS_MAX, COORD_POS_MAX, 0);
  endtask

  task automatic test_z_and_bounds();
    settle();
    configure(5'd16, 1'b0);
    send_item(FUNC_QUERY, 4'd0, 100, 200, 999);
    send_item(FUNC_QUERY, 4'd0, 100, 200, 300);
    send_item(FUNC_FIRST, 4'd7, 0, 0, 0);
    send_item(FUNC_GROW, 4'd7, 10, 10, 10);
    send_item(FUNC_QUERY, 4'd0, 10, 0, 10);
    send_item(FUNC_QUERY, 4'd0, 11, 0, 5);
    send_item(FUNC_QUERY, 4'd0, 5, 5, -1);
  endtask

  task automatic test_count_limits();
    settle();
    configure(5'd31, 1'b0);
    send_item(FUNC_QUERY, 4'd0, 10, 10, 10);
    settle();
    configure(5'd7, 1'b0);
    send_item(FUNC_QUERY, 4'd0, 10, 10, 10);
    settle();
    configure(5'd8, 1'b1);
    send_item(FUNC_QUERY, 4'd0, 10, 10, 10);
    settle();
  endtask

  task automatic test_backpressure();
    configure(5'd16, 1'b1);
    no_gaps = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (40) send_item(FUNC_QUERY, 4'($urandom), rand_coord(), rand_coord(), rand_coord());
    no_gaps = 1'b0;
    settle();
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] count;
    int                 pick;
    logic [FUNC_W-1:0]  func;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: count = 5'd16;
        1: count = 5'd0;
        2: count = 5'd31;
        3: count = 5'd1;
        default: count = 5'($urandom_range(31));
      endcase
      configure(count, (phase < 2) ? phase[0] : 1'($urandom));
      no_gaps = (phase == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 15) func = FUNC_FIRST;
        else if (pick < 50) func = FUNC_GROW;
        else if (pick < 96) func = FUNC_QUERY;
        else func = FUNC_UNUSED;
        send_item(func, 4'($urandom), rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(99) == 0) drain_results();
      end
      no_gaps = 1'b0;
      settle();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_lookups.size() == 0) begin
        flag_mismatch($sformatf("unexpected lookup result: found=%0d index=%0d",
                                result_bus.found, result_bus.match_index));
      end else begin
        want = pending_lookups.pop_front();
        if (result_bus.found !== want.found || result_bus.match_index !== want.index)
          flag_mismatch($sformatf(
            "lookup mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
            want.found, want.index, result_bus.found, result_bus.match_index));
      end
    end
  end

  // result receiver with random and requested hold-offs
  initial begin
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= no_gaps || ($urandom_range(99) >= 10);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    item_bus.valid        <= 1'b0;
    item_bus.func         <= '0;
    item_bus.region_index <= '0;
    item_bus.x_coord      <= '0;
    item_bus.y_coord      <= '0;
    item_bus.z_coord      <= '0;
    search_count = '0;
    skip_z       = 1'b1;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      lo_x[r] = COORD_POS_MAX; lo_y[r] = COORD_POS_MAX; lo_z[r] = COORD_POS_MAX;
      hi_x[r] = COORD_NEG_MIN; hi_y[r] = COORD_NEG_MIN; hi_z[r] = COORD_NEG_MIN;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_regions();
    test_vertex_updates();
    test_z_and_bounds();
    test_count_limits();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
